@@ design/gha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

    // Table geometry.
    localparam int SLOT_COUNT   = 1024;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = $clog2(SLOT_COUNT);
    localparam int CNT_W        = $clog2(SLOT_COUNT + 1);

    // Handle layout.
    localparam int HANDLE_BITS  = 32;
    localparam int VER_BITS     = 16;
    localparam int HIDX_BITS    = 16;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH  = 2;
    localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request function codes.
    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Classified operation carried through the queue.
    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_LOOKUP,
        OP_RANGE,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] handle_in;
        logic [31:0] payload_in;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] handle_out;
        logic [31:0] payload_out;
        logic [1:0]  status;
    } t_out_beat;

    typedef struct packed {
        t_op         op;
        logic [31:0] handle;
        logic [31:0] payload;
    } t_queue_entry;

    // Back-to-front control.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctrl;

endpackage

`default_nettype wire

@@ design/gha_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gha_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  gha_pkg::t_in_beat       i_in,
    output logic                    o_q_valid,
    output gha_pkg::t_queue_entry   o_q_entry,
    input  gha_pkg::t_back_ctrl     i_back
);

    gha_pkg::t_queue_entry                 r_queue [gha_pkg::QUEUE_DEPTH];
    logic [gha_pkg::Q_PTR_W-1:0]           r_wr_ptr;
    logic [gha_pkg::Q_PTR_W-1:0]           r_rd_ptr;
    logic [gha_pkg::Q_CNT_W-1:0]           r_count;
    gha_pkg::t_queue_entry                 w_entry;
    logic                                  w_push;
    logic                                  w_out_of_range;

    // Classify the incoming beat; the index range check is done here once.
    assign w_out_of_range = {1'b0, i_in.handle_in[gha_pkg::HIDX_BITS-1:0]}
                            >= (gha_pkg::HIDX_BITS + 1)'(gha_pkg::SLOT_COUNT);

    always_comb begin
        w_entry.handle  = i_in.handle_in;
        w_entry.payload = i_in.payload_in;
        unique case (i_in.func)
            gha_pkg::FUNC_ALLOC: begin
                w_entry.op = gha_pkg::OP_ALLOC;
            end
            gha_pkg::FUNC_FREE: begin
                w_entry.op = w_out_of_range ? gha_pkg::OP_RANGE : gha_pkg::OP_FREE;
            end
            gha_pkg::FUNC_LOOKUP: begin
                w_entry.op = w_out_of_range ? gha_pkg::OP_RANGE : gha_pkg::OP_LOOKUP;
            end
            default: begin
                w_entry.op = gha_pkg::OP_NOP;
            end
        endcase
    end

    // Hold off the sender while the queue is full or the table is being cleared.
    assign o_in_stall = (r_count == gha_pkg::Q_CNT_W'(gha_pkg::QUEUE_DEPTH)) ||
                        i_back.clearing;
    assign w_push     = i_in_valid && !o_in_stall;

    assign o_q_valid  = (r_count != '0);
    assign o_q_entry  = r_queue[r_rd_ptr];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + gha_pkg::Q_PTR_W'(1);
            end
            if (i_back.pop) begin
                r_rd_ptr <= r_rd_ptr + gha_pkg::Q_PTR_W'(1);
            end
            if (w_push && !i_back.pop) begin
                r_count <= r_count + gha_pkg::Q_CNT_W'(1);
            end else if (!w_push && i_back.pop) begin
                r_count <= r_count - gha_pkg::Q_CNT_W'(1);
            end
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_entry;
        end
    end

endmodule

`default_nettype wire

@@ design/gha_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gha_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_q_valid,
    input  gha_pkg::t_queue_entry   i_q_entry,
    output gha_pkg::t_back_ctrl     o_ctrl,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output gha_pkg::t_out_beat      o_out
);

    localparam int IW = gha_pkg::IDX_W;
    localparam int CW = gha_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic                          occupied;
        logic [gha_pkg::VER_BITS-1:0]  version;
    } t_slot_meta;

    // Slot tables and free stack.
    t_slot_meta                        r_meta_mem  [gha_pkg::SLOT_COUNT];
    logic [gha_pkg::PAYLOAD_BITS-1:0]  r_pay_mem   [gha_pkg::SLOT_COUNT];
    logic [IW-1:0]                     r_stack_mem [gha_pkg::SLOT_COUNT];
    t_slot_meta                        r_meta_q;
    logic [gha_pkg::PAYLOAD_BITS-1:0]  r_pay_q;
    logic [IW-1:0]                     r_stack_q;

    // Control and result registers.
    t_state                r_state,     n_state;
    logic [IW-1:0]         r_clr_idx,   n_clr_idx;
    logic [CW-1:0]         r_hw,        n_hw;
    logic [CW-1:0]         r_fc,        n_fc;
    gha_pkg::t_queue_entry r_cmd,       n_cmd;
    logic [IW-1:0]         r_slot,      n_slot;
    logic                  r_from_hw,   n_from_hw;
    logic                  r_out_valid, n_out_valid;
    gha_pkg::t_out_beat    r_out,       n_out;

    // Memory port controls.
    logic [IW-1:0]                     w_meta_raddr;
    logic [IW-1:0]                     w_stack_raddr;
    logic                              w_meta_we;
    logic [IW-1:0]                     w_meta_waddr;
    t_slot_meta                        w_meta_wdata;
    logic                              w_pay_we;
    logic                              w_stack_we;
    logic [IW-1:0]                     w_stack_waddr;
    logic                              w_out_free;
    logic                              w_pop;
    logic                              w_live;
    logic [IW-1:0]                     w_idx;

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_pop        = (r_state == S_IDLE) && i_q_valid && w_out_free;
    assign w_idx        = i_q_entry.handle[IW-1:0];
    assign w_live       = r_meta_q.occupied &&
                          (r_meta_q.version ==
                           r_cmd.handle[gha_pkg::HANDLE_BITS-1:gha_pkg::HIDX_BITS]);
    assign w_stack_raddr = IW'(r_fc - CW'(1));

    assign o_ctrl.pop      = w_pop;
    assign o_ctrl.clearing = (r_state == S_CLEAR);
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    // Sequencer: reads on pop, tables and result set in execute, or result at pop if no read.
    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_hw         = r_hw;
        n_fc         = r_fc;
        n_cmd        = r_cmd;
        n_slot       = r_slot;
        n_from_hw    = r_from_hw;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        w_meta_raddr = r_slot;
        w_meta_we    = 1'b0;
        w_meta_waddr = r_slot;
        w_meta_wdata = r_meta_q;
        w_pay_we     = 1'b0;
        w_stack_we   = 1'b0;
        w_stack_waddr = IW'(r_fc);

        unique case (r_state)
            S_CLEAR: begin
                w_meta_we             = 1'b1;
                w_meta_waddr          = r_clr_idx;
                w_meta_wdata.occupied = 1'b0;
                w_meta_wdata.version  = gha_pkg::VER_BITS'(1);
                n_clr_idx             = r_clr_idx + IW'(1);
                if (r_clr_idx == IW'(gha_pkg::SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_pop) begin
                    n_cmd = i_q_entry;
                    n_out.handle_out  = i_q_entry.handle;
                    n_out.payload_out = '0;
                    unique case (i_q_entry.op)
                        gha_pkg::OP_ALLOC: begin
                            if (r_hw != CW'(gha_pkg::SLOT_COUNT)) begin
                                n_slot       = IW'(r_hw);
                                w_meta_raddr = IW'(r_hw);
                                n_from_hw    = 1'b1;
                                n_state      = S_EXEC;
                            end else if (r_fc != '0) begin
                                n_from_hw = 1'b0;
                                n_state   = S_POP;
                            end else begin
                                n_out.status = gha_pkg::ST_FULL;
                                n_out_valid  = 1'b1;
                            end
                        end
                        gha_pkg::OP_FREE, gha_pkg::OP_LOOKUP: begin
                            n_slot       = w_idx;
                            w_meta_raddr = w_idx;
                            n_state      = S_EXEC;
                        end
                        gha_pkg::OP_RANGE: begin
                            n_out.status = gha_pkg::ST_RANGE;
                            n_out_valid  = 1'b1;
                        end
                        default: begin
                            n_out.status = gha_pkg::ST_OK;
                            n_out_valid  = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                // Stack top arrived; now read the popped slot's version.
                n_slot       = r_stack_q;
                w_meta_raddr = r_stack_q;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                n_state           = S_IDLE;
                n_out_valid       = 1'b1;
                n_out.handle_out  = r_cmd.handle;
                n_out.payload_out = '0;
                n_out.status      = gha_pkg::ST_OK;
                unique case (r_cmd.op)
                    gha_pkg::OP_ALLOC: begin
                        w_meta_we             = 1'b1;
                        w_meta_wdata.occupied = 1'b1;
                        w_meta_wdata.version  = r_meta_q.version;
                        w_pay_we              = 1'b1;
                        n_out.handle_out      = {r_meta_q.version,
                                                 gha_pkg::HIDX_BITS'(r_slot)};
                        if (r_from_hw) begin
                            n_hw = r_hw + CW'(1);
                        end else begin
                            n_fc = r_fc - CW'(1);
                        end
                    end
                    gha_pkg::OP_FREE: begin
                        if (!w_live) begin
                            n_out.status = gha_pkg::ST_STALE;
                        end else begin
                            w_meta_we             = 1'b1;
                            w_meta_wdata.occupied = 1'b0;
                            w_meta_wdata.version  = r_meta_q.version +
                                                    gha_pkg::VER_BITS'(1);
                            // Topmost slot lowers the high-water mark, others go on the stack.
                            if ((CW'(r_slot) + CW'(1)) == r_hw) begin
                                n_hw = r_hw - CW'(1);
                            end else if (r_fc != CW'(gha_pkg::SLOT_COUNT)) begin
                                w_stack_we = 1'b1;
                                n_fc       = r_fc + CW'(1);
                            end
                        end
                    end
                    gha_pkg::OP_LOOKUP: begin
                        if (!w_live) begin
                            n_out.status = gha_pkg::ST_STALE;
                        end else begin
                            n_out.payload_out = 32'(r_pay_q);
                        end
                    end
                    default: begin
                        n_out.status = gha_pkg::ST_OK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_hw        <= '0;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_hw        <= n_hw;
            r_fc        <= n_fc;
            r_out_valid <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_slot    <= n_slot;
        r_from_hw <= n_from_hw;
        r_out     <= n_out;
    end

    // Slot metadata and payload memories, registered reads.
    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            r_meta_mem[w_meta_waddr] <= w_meta_wdata;
        end
        r_meta_q <= r_meta_mem[w_meta_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_pay_we) begin
            r_pay_mem[r_slot] <= r_cmd.payload[gha_pkg::PAYLOAD_BITS-1:0];
        end
        r_pay_q <= r_pay_mem[w_meta_raddr];
    end

    // Free stack memory.
    always_ff @(posedge i_clk) begin
        if (w_stack_we) begin
            r_stack_mem[w_stack_waddr] <= r_slot;
        end
        r_stack_q <= r_stack_mem[w_stack_raddr];
    end

    // The counters never pass the table size.
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hw <= CW'(gha_pkg::SLOT_COUNT)) && (r_fc <= CW'(gha_pkg::SLOT_COUNT)))
        else $error("high-water mark or free count out of bounds");

    // No command is taken from the queue during the clearing pass.
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !w_pop)
        else $error("queue popped while clearing");

    // An execute cycle always delivers a result and returns to idle.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("execute cycle did not produce a result");

    // A pop from the free stack only happens when the stack holds entries.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_fc != '0))
        else $error("free stack popped while empty");

    // A result waiting under stall is never overwritten.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result was overwritten");

endmodule

`default_nettype wire

@@ design/generational_handle_allocator_unit.sv @@
// Generational handle allocator: hands out versioned 32-bit handles for a
// table of SLOT_COUNT slots, frees them and looks them up.
// Input channel: i_in_valid / o_in_stall carry one request beat (func,
// handle_in, payload_in). Output channel: o_out_valid / i_out_stall carry
// one result beat (handle_out, payload_out, status) for every request.
// A beat passes a two-entry command queue, then the execution back end.
// Full, out-of-range and undefined requests are answered as the back end
// takes them from the queue; allocate from the high-water mark, free and
// lookup first read the slot memory and answer from the execute state;
// allocate from the free stack first reads the free stack top. The back
// end takes no new request until it has answered the last one, nor
// while a waiting result is held by i_out_stall.
// After reset the back end clears the version and occupied table, one slot
// a cycle, for SLOT_COUNT (1024) slots; o_in_stall stays high meanwhile.
// When the receiver stalls, the result beat holds in the output register,
// the back end stops taking commands and the queue fills, after which
// o_in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  gha_pkg::t_in_beat   i_in,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output gha_pkg::t_out_beat  o_out
);

    logic                   w_q_valid;
    gha_pkg::t_queue_entry  w_q_entry;
    gha_pkg::t_back_ctrl    w_back;

    // Front: classify requests and queue them.
    gha_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_q_valid  (w_q_valid),
        .o_q_entry  (w_q_entry),
        .i_back     (w_back)
    );

    // Back: slot tables, free stack and result register.
    gha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_ctrl      (w_back),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    // Function code with no operation behind it; the block only echoes its handle with status OK.
    localparam logic [1:0] FUNC_UNDEF = 2'd3;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    // Mirror of the slot table. It predicts one result beat per request beat,
    // and keeps the handles that are live so that the stimulus can use them.
    class slot_map_scoreboard;
        logic [15:0]               slot_ver [gha_pkg::SLOT_COUNT];
        logic [31:0]               slot_tag [gha_pkg::SLOT_COUNT];
        bit                        slot_used [gha_pkg::SLOT_COUNT];
        logic [gha_pkg::IDX_W-1:0] spare_slots [gha_pkg::SLOT_COUNT];
        int unsigned               top;
        int unsigned               spare_cnt;
        gha_pkg::t_out_beat        due_results [$];
        logic [31:0]               live [$];
        int                        mismatches;

        function new();
            foreach (slot_ver[i]) begin
                slot_ver[i]  = 16'd1;
                slot_used[i] = 1'b0;
            end
            top        = 0;
            spare_cnt  = 0;
            mismatches = 0;
        endfunction

        // Work out the result of one accepted request and update the table.
        function void note_request(gha_pkg::t_in_beat rq);
            gha_pkg::t_out_beat        want;
            logic [gha_pkg::IDX_W-1:0] slot;
            logic [15:0]               idx;
            logic [15:0]               ver;
            idx = rq.handle_in[15:0];
            ver = rq.handle_in[31:16];
            want.handle_out  = rq.handle_in;
            want.payload_out = '0;
            want.status      = gha_pkg::ST_OK;
            slot             = '0;
            case (rq.func)
                gha_pkg::FUNC_ALLOC: begin
                    if (top < gha_pkg::SLOT_COUNT) begin
                        slot = top[gha_pkg::IDX_W-1:0];
                        top++;
                    end else if (spare_cnt > 0) begin
                        spare_cnt--;
                        slot = spare_slots[spare_cnt];
                    end else begin
                        want.status = gha_pkg::ST_FULL;
                    end
                    if (want.status == gha_pkg::ST_OK) begin
                        slot_used[slot] = 1'b1;
                        slot_tag[slot]  = rq.payload_in;
                        want.handle_out = {slot_ver[slot], 16'(slot)};
                        live.insert(live.size(), want.handle_out);
                    end
                end
                gha_pkg::FUNC_FREE, gha_pkg::FUNC_LOOKUP: begin
                    if (idx >= gha_pkg::SLOT_COUNT) begin
                        want.status = gha_pkg::ST_RANGE;
                    end else if (!slot_used[idx] || slot_ver[idx] != ver) begin
                        want.status = gha_pkg::ST_STALE;
                    end else if (rq.func == gha_pkg::FUNC_LOOKUP) begin
                        want.payload_out = slot_tag[idx];
                    end else begin
                        // The version moves on, so every old handle goes stale.
                        slot_ver[idx]  = slot_ver[idx] + 16'd1;
                        slot_used[idx] = 1'b0;
                        if (top > 0 && idx == top - 1) begin
                            top--;
                        end else begin
                            spare_slots[spare_cnt] = idx[gha_pkg::IDX_W-1:0];
                            spare_cnt++;
                        end
                        for (int i = 0; i < live.size(); i++) begin
                            if (live[i] == rq.handle_in) begin
                                live.delete(i);
                                break;
                            end
                        end
                    end
                end
                default: ;
            endcase
            due_results.insert(due_results.size(), want);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one accepted result beat with the oldest prediction.
        task check_result(gha_pkg::t_out_beat got);
            gha_pkg::t_out_beat want;
            if (due_results.size() == 0) begin
                report($sformatf("result beat %h with nothing outstanding", got));
            end else begin
                want = due_results.pop_front();
                if (got.handle_out !== want.handle_out)
                    report($sformatf("handle_out %h, expected %h",
                                     got.handle_out, want.handle_out));
                if (got.payload_out !== want.payload_out)
                    report($sformatf("payload_out %h, expected %h",
                                     got.payload_out, want.payload_out));
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    gha_pkg::t_in_beat  i_in = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    gha_pkg::t_out_beat o_out;

    slot_map_scoreboard sb;
    bit      quiet = 1'b0;
    int      stall_left = 0;
    longint  cycles = 0;

    generational_handle_allocator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: stall in bursts of random length, started at random.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(4) == 0) begin
            stall_left = $urandom_range(7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result beats are taken where valid is high and stall is low.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_result(o_out);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[generational_handle_allocator_unit] ERROR");
            $finish;
        end
    end

    // Present one request beat, hold it until accepted, then maybe idle.
    task automatic send_request(input logic [1:0] func, input logic [31:0] handle,
                                input logic [31:0] payload);
        gha_pkg::t_in_beat rq;
        rq.func       = func;
        rq.handle_in  = handle;
        rq.payload_in = payload;
        i_in_valid <= 1'b1;
        i_in       <= rq;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(rq);
        if (!quiet && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Random request: mostly allocations and uses of live handles, with some
    // noise of stale, out-of-range, random and undefined requests.
    function automatic gha_pkg::t_in_beat pick_request(int alloc_pct);
        gha_pkg::t_in_beat rq;
        int                r;
        rq.func       = gha_pkg::FUNC_ALLOC;
        rq.handle_in  = $urandom;
        rq.payload_in = $urandom;
        r = $urandom_range(99);
        if (r < alloc_pct)
            return rq;
        if (sb.live.size() == 0 || r >= 88) begin
            case ($urandom_range(3))
                0: rq.func = 2'($urandom_range(3));
                1: begin
                    rq.func = $urandom_range(1) ? gha_pkg::FUNC_FREE : gha_pkg::FUNC_LOOKUP;
                    rq.handle_in[15:0] =
                        16'($urandom_range(gha_pkg::SLOT_COUNT, 16'hFFFF));
                end
                2: begin
                    rq.func = $urandom_range(1) ? gha_pkg::FUNC_FREE : gha_pkg::FUNC_LOOKUP;
                    if (sb.live.size() != 0) begin
                        rq.handle_in = sb.live[$urandom_range(sb.live.size() - 1)];
                        rq.handle_in[31:16] ^= 16'($urandom_range(1, 16'hFFFF));
                    end
                end
                default: begin
                    rq.func = $urandom_range(1) ? gha_pkg::FUNC_FREE : gha_pkg::FUNC_LOOKUP;
                    rq.handle_in = {16'($urandom_range(1, 4)),
                                    16'($urandom_range(gha_pkg::SLOT_COUNT - 1))};
                end
            endcase
        end else begin
            rq.handle_in = sb.live[$urandom_range(sb.live.size() - 1)];
            rq.func = (r < alloc_pct + (88 - alloc_pct) / 2) ?
                      gha_pkg::FUNC_FREE : gha_pkg::FUNC_LOOKUP;
        end
        return rq;
    endfunction

    initial begin
        gha_pkg::t_in_beat rq;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats: extreme fields, every function and the corner cases.
        send_request(gha_pkg::FUNC_ALLOC, 32'h0000_0000, 32'h0000_0000);
        send_request(gha_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(gha_pkg::FUNC_ALLOC, 32'h0000_0000, 32'hA5A5_5A5A);
        send_request(gha_pkg::FUNC_LOOKUP, 32'h0001_0000, 32'h0000_0000);
        send_request(gha_pkg::FUNC_LOOKUP, 32'h0001_0001, 32'hFFFF_FFFF);
        // Wrong version on a live slot.
        send_request(gha_pkg::FUNC_LOOKUP, 32'h0002_0001, 32'h0000_0000);
        // Indexes at and far above the table size.
        send_request(gha_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(gha_pkg::FUNC_LOOKUP, {16'd1, 16'(gha_pkg::SLOT_COUNT)},
                     32'h0000_0000);
        send_request(gha_pkg::FUNC_FREE, {16'd1, 16'(gha_pkg::SLOT_COUNT)},
                     32'h0000_0000);
        // Slots never taken.
        send_request(gha_pkg::FUNC_FREE, 32'h0001_0005, 32'h0000_0000);
        send_request(gha_pkg::FUNC_LOOKUP, {16'd1, 16'(gha_pkg::SLOT_COUNT - 1)},
                     32'h0000_0000);
        // A slot below the top goes on the free stack; a second free is stale.
        send_request(gha_pkg::FUNC_FREE, 32'h0001_0001, 32'h0000_0000);
        send_request(gha_pkg::FUNC_FREE, 32'h0001_0001, 32'h0000_0000);
        send_request(gha_pkg::FUNC_LOOKUP, 32'h0001_0001, 32'h0000_0000);
        // The topmost slot lowers the high-water mark and is taken again.
        send_request(gha_pkg::FUNC_FREE, 32'h0001_0002, 32'h0000_0000);
        send_request(gha_pkg::FUNC_ALLOC, 32'h0000_0000, 32'h1234_5678);
        send_request(gha_pkg::FUNC_LOOKUP, 32'h0002_0002, 32'h0000_0000);
        send_request(FUNC_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_UNDEF, 32'h0000_0000, 32'h0000_0000);
        send_request(gha_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_request(gha_pkg::FUNC_FREE, 32'h0001_0000, 32'h0000_0000);

        // Mixed traffic while the table is partly used.
        repeat (250) begin
            rq = pick_request(50);
            send_request(rq.func, rq.handle_in, rq.payload_in);
        end

        // Fill the table, then try a few allocations against the full table.
        while (!(sb.top == gha_pkg::SLOT_COUNT && sb.spare_cnt == 0)) begin
            rq = pick_request(85);
            send_request(rq.func, rq.handle_in, rq.payload_in);
        end
        repeat (8) begin
            rq = pick_request(100);
            send_request(rq.func, rq.handle_in, rq.payload_in);
        end

        // Churn near full: slots come back from the free stack.
        repeat (200) begin
            rq = pick_request(45);
            send_request(rq.func, rq.handle_in, rq.payload_in);
        end

        // Last stretch at full rate on both sides.
        quiet = 1'b1;
        repeat (150) begin
            rq = pick_request(45);
            send_request(rq.func, rq.handle_in, rq.payload_in);
        end
        i_in_valid <= 1'b0;

        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("[generational_handle_allocator_unit] OK");
        end else begin
            $display("[generational_handle_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/gha_pkg.sv
design/gha_front.sv
design/gha_back.sv
design/generational_handle_allocator_unit.sv
test/tb_top.sv
